FILE: design/vpa_pkg.sv
// Shared types and constants for the variable partition allocator.
// Holds segment record layout, command/status/policy codes, controller
// states and the controller-to-datapath command and status types.
`timescale 1ns / 1ps
package vpa_pkg;

  localparam int ADDR_BITS       = 16;
  localparam int SIZE_BITS       = ADDR_BITS + 1;
  localparam int OWNER_BITS      = 8;
  localparam int MAP_ENTRIES_DEF = 16;

  localparam logic [1:0] CMD_INIT     = 2'd0;
  localparam logic [1:0] CMD_ALLOC    = 2'd1;
  localparam logic [1:0] CMD_RELEASE  = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_MEM_SIZE   = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  start;
    logic [ADDR_BITS-1:0]  stop;
    logic [SIZE_BITS-1:0]  size;
    logic [OWNER_BITS-1:0] owner;
  } seg_t;

  localparam int SEG_BITS = $bits(seg_t);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_DECIDE, S_MOVE, S_WRITE_A, S_WRITE_B, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_SCAN_START, OP_SCAN, OP_NOFIT, OP_FULL,
    OP_NOTFOUND, OP_OWNER, OP_MOVE_START, OP_MOVE, OP_WRITE_A, OP_WRITE_B,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_done;
    logic       move_done;
    logic       pick_ok;
    logic       pick_exact;
    logic       map_full;
    logic       found;
    logic       out_busy;
  } dp_stat_t;

endpackage

FILE: design/vpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/vpa_ctrl.sv
// Command sequencer for the allocator: walks init, scan, split/merge moves.
// Depends on vpa_pkg for states, datapath ops and status struct.
`timescale 1ns / 1ps
module vpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vpa_pkg::dp_stat_t  stat,
  output vpa_pkg::dp_op_t    op
);
  import vpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.cmd == CMD_INIT) begin
          op         = OP_INIT;
          state_next = S_DONE;
        end else if (stat.cmd == CMD_ALLOC || stat.cmd == CMD_RELEASE) begin
          op         = OP_SCAN_START;
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end else begin
          op = OP_SCAN;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        if (stat.cmd == CMD_ALLOC) begin
          if (!stat.pick_ok) begin
            op = OP_NOFIT;
          end else if (stat.pick_exact) begin
            op = OP_OWNER;
          end else if (stat.map_full) begin
            op = OP_FULL;
          end else begin
            op         = OP_MOVE_START;
            state_next = S_MOVE;
          end
        end else if (!stat.found) begin
          op = OP_NOTFOUND;
        end else begin
          op         = OP_MOVE_START;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        if (stat.move_done) begin
          state_next = S_WRITE_A;
        end else begin
          op = OP_MOVE;
        end
      end
      S_WRITE_A: begin
        op         = OP_WRITE_A;
        state_next = (stat.cmd == CMD_ALLOC) ? S_WRITE_B : S_DONE;
      end
      S_WRITE_B: begin
        op         = OP_WRITE_B;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          op         = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

FILE: design/vpa_dp.sv
// Allocator datapath: segment map RAM, scan trackers, move pipeline, result.
// Depends on vpa_pkg and vpa_ram.
`timescale 1ns / 1ps
module vpa_dp #(
  parameter int MAP_ENTRIES = vpa_pkg::MAP_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vpa_pkg::dp_op_t                    op,
  output vpa_pkg::dp_stat_t                  stat,
  input  logic [1:0]                         fit_policy,
  input  logic [vpa_pkg::SIZE_BITS-1:0]      mem_size,
  input  logic [1:0]                         command,
  input  logic [vpa_pkg::SIZE_BITS-1:0]      req_size,
  input  logic [vpa_pkg::OWNER_BITS-1:0]     owner_id,
  input  logic [vpa_pkg::ADDR_BITS-1:0]      scan_from,
  input  logic [vpa_pkg::ADDR_BITS-1:0]      block_start,
  input  logic [vpa_pkg::ADDR_BITS-1:0]      block_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vpa_pkg::ADDR_BITS-1:0]      out_start,
  output logic [vpa_pkg::ADDR_BITS-1:0]      out_end,
  output logic [vpa_pkg::SIZE_BITS-1:0]      out_size,
  output logic [vpa_pkg::OWNER_BITS-1:0]     out_owner,
  output logic [1:0]                         status,
  output logic [$clog2(MAP_ENTRIES+1)-1:0]   entry_count_out
);
  import vpa_pkg::*;

  localparam int IW = $clog2(MAP_ENTRIES);
  localparam int CW = $clog2(MAP_ENTRIES + 1);

  logic [1:0]            cmd_q;
  logic [SIZE_BITS-1:0]  req_q;
  logic [OWNER_BITS-1:0] own_q;
  logic [ADDR_BITS-1:0]  last_q, bs_q, be_q;

  logic [CW-1:0] cnt, iss, mv_left;
  logic          rv;
  logic [IW-1:0] ridx;

  logic          alt_ok, pk_ok, seen;
  logic [IW-1:0] alt_idx, pk_idx;
  seg_t          alt_seg, pk_seg;

  logic          found, need_next, nxt_ok;
  logic [IW-1:0] t_idx;
  seg_t          tgt, prev_seg, last_seg, nxt_seg;

  logic [IW-1:0] mv_src, pend_dst;
  logic          mv_down, pend;
  logic [1:0]    mv_rem;

  seg_t       res_seg;
  logic [1:0] res_st;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  seg_t                ram_wdata;
  logic [SEG_BITS-1:0] ram_rdata;
  seg_t                rd_seg;

  vpa_ram #(.WIDTH(SEG_BITS), .DEPTH(MAP_ENTRIES)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_seg = seg_t'(ram_rdata);

  // Effective pick per policy; next fit falls back to the first fit overall.
  logic          sel_ok;
  logic [IW-1:0] sel_idx;
  seg_t          sel_seg;

  always_comb begin
    if (fit_policy == POL_FIRST || (fit_policy == POL_NEXT && !pk_ok)) begin
      sel_ok  = alt_ok;
      sel_idx = alt_idx;
      sel_seg = alt_seg;
    end else begin
      sel_ok  = pk_ok;
      sel_idx = pk_idx;
      sel_seg = pk_seg;
    end
  end

  logic          merge_l, merge_r;
  logic [IW-1:0] rel_base;
  logic [1:0]    rel_rem;
  seg_t          merged, a_seg, rem_seg, own_seg, init_seg;
  logic [SIZE_BITS-1:0] msz;

  always_comb begin
    merge_l  = (t_idx != '0) && (prev_seg.owner == '0);
    merge_r  = nxt_ok && (nxt_seg.owner == '0);
    rel_base = merge_l ? (t_idx - 1'b1) : t_idx;
    rel_rem  = {1'b0, merge_l} + {1'b0, merge_r};

    merged.start = merge_l ? prev_seg.start : tgt.start;
    merged.stop  = merge_r ? nxt_seg.stop : tgt.stop;
    merged.size  = SIZE_BITS'(tgt.size + (merge_l ? prev_seg.size : '0)
                              + (merge_r ? nxt_seg.size : '0));
    merged.owner = '0;

    a_seg.start = sel_seg.start;
    a_seg.stop  = ADDR_BITS'(sel_seg.start + req_q - 1'b1);
    a_seg.size  = req_q;
    a_seg.owner = own_q;

    rem_seg.start = ADDR_BITS'(sel_seg.start + req_q);
    rem_seg.stop  = sel_seg.stop;
    rem_seg.size  = SIZE_BITS'(sel_seg.size - req_q);
    rem_seg.owner = '0;

    own_seg       = sel_seg;
    own_seg.owner = own_q;

    // clamp the init size to [1, 2^ADDR_BITS]
    if (mem_size == '0) begin
      msz = SIZE_BITS'(1);
    end else if (mem_size > (SIZE_BITS'(1) << ADDR_BITS)) begin
      msz = SIZE_BITS'(1) << ADDR_BITS;
    end else begin
      msz = mem_size;
    end
    init_seg.start = '0;
    init_seg.stop  = ADDR_BITS'(msz - 1'b1);
    init_seg.size  = msz;
    init_seg.owner = '0;
  end

  // RAM port steering
  always_comb begin
    ram_raddr = (op == OP_MOVE) ? mv_src : iss[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = init_seg;
    case (op)
      OP_INIT: begin
        ram_we = 1'b1;
      end
      OP_MOVE: begin
        ram_we    = pend;
        ram_waddr = pend_dst;
        ram_wdata = rd_seg;
      end
      OP_OWNER: begin
        ram_we    = 1'b1;
        ram_waddr = sel_idx;
        ram_wdata = own_seg;
      end
      OP_WRITE_A: begin
        ram_we    = 1'b1;
        ram_waddr = (cmd_q == CMD_ALLOC) ? sel_idx : rel_base;
        ram_wdata = (cmd_q == CMD_ALLOC) ? a_seg : merged;
      end
      OP_WRITE_B: begin
        ram_we    = 1'b1;
        ram_waddr = sel_idx + 1'b1;
        ram_wdata = rem_seg;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  logic e_fit, e_seen, e_match;

  always_comb begin
    e_fit   = (rd_seg.owner == '0) && (rd_seg.size >= req_q) && (req_q != '0);
    e_seen  = seen || (rd_seg.start >= last_q);
    e_match = (rd_seg.start == bs_q) && (rd_seg.stop == be_q) &&
              (rd_seg.size == req_q) && (rd_seg.owner == own_q);
  end

  always_comb begin
    stat.cmd        = cmd_q;
    stat.scan_done  = (iss == cnt) && !rv;
    stat.move_done  = (mv_left == '0) && !pend;
    stat.pick_ok    = sel_ok;
    stat.pick_exact = (sel_seg.size == req_q);
    stat.map_full   = (cnt >= CW'(MAP_ENTRIES));
    stat.found      = found;
    stat.out_busy   = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      iss       <= '0;
      rv        <= 1'b0;
      pend      <= 1'b0;
      mv_left   <= '0;
      found     <= 1'b0;
      need_next <= 1'b0;
      nxt_ok    <= 1'b0;
      alt_ok    <= 1'b0;
      pk_ok     <= 1'b0;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on publish, drop it once the beat is taken.
      if (op == OP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          cmd_q   <= command;
          req_q   <= req_size;
          own_q   <= owner_id;
          last_q  <= scan_from;
          bs_q    <= block_start;
          be_q    <= block_end;
          res_seg <= '0;
          res_st  <= ST_OK;
        end
        OP_INIT: begin
          cnt <= CW'(1);
        end
        OP_SCAN_START: begin
          iss       <= '0;
          rv        <= 1'b0;
          alt_ok    <= 1'b0;
          pk_ok     <= 1'b0;
          seen      <= 1'b0;
          found     <= 1'b0;
          need_next <= 1'b0;
          nxt_ok    <= 1'b0;
        end
        OP_SCAN: begin
          rv <= (iss != cnt);
          if (iss != cnt) begin
            ridx <= iss[IW-1:0];
            iss  <= iss + 1'b1;
          end
          if (rv) begin
            last_seg <= rd_seg;
            seen     <= e_seen;
            if (e_fit && !alt_ok) begin
              alt_ok  <= 1'b1;
              alt_idx <= ridx;
              alt_seg <= rd_seg;
            end
            if (e_fit && ((fit_policy == POL_BEST &&
                           (!pk_ok || rd_seg.size < pk_seg.size)) ||
                          (fit_policy == POL_WORST &&
                           (!pk_ok || rd_seg.size > pk_seg.size)) ||
                          (fit_policy == POL_NEXT && e_seen && !pk_ok))) begin
              pk_ok  <= 1'b1;
              pk_idx <= ridx;
              pk_seg <= rd_seg;
            end
            if (e_match && !found) begin
              found     <= 1'b1;
              t_idx     <= ridx;
              tgt       <= rd_seg;
              prev_seg  <= last_seg;
              need_next <= 1'b1;
            end else if (need_next) begin
              nxt_seg   <= rd_seg;
              nxt_ok    <= 1'b1;
              need_next <= 1'b0;
            end
          end
        end
        OP_NOFIT: begin
          res_st <= ST_NOFIT;
        end
        OP_FULL: begin
          res_st <= ST_FULL;
        end
        OP_NOTFOUND: begin
          res_st <= ST_NOTFOUND;
        end
        OP_OWNER: begin
          res_seg <= own_seg;
        end
        OP_MOVE_START: begin
          pend <= 1'b0;
          if (cmd_q == CMD_ALLOC) begin
            mv_down <= 1'b1;
            mv_left <= cnt - CW'(sel_idx) - 1'b1;
            mv_src  <= IW'(cnt - 1'b1);
          end else begin
            mv_down <= 1'b0;
            mv_rem  <= rel_rem;
            mv_left <= cnt - CW'(rel_base) - CW'(rel_rem) - 1'b1;
            mv_src  <= IW'(CW'(rel_base) + CW'(rel_rem) + 1'b1);
          end
        end
        OP_MOVE: begin
          pend <= (mv_left != '0);
          if (mv_left != '0) begin
            pend_dst <= mv_down ? (mv_src + 1'b1) : (mv_src - IW'(mv_rem));
            mv_src   <= mv_down ? (mv_src - 1'b1) : (mv_src + 1'b1);
            mv_left  <= mv_left - 1'b1;
          end
        end
        OP_WRITE_A: begin
          if (cmd_q == CMD_ALLOC) begin
            res_seg <= a_seg;
          end else begin
            cnt <= cnt - CW'(rel_rem);
          end
        end
        OP_WRITE_B: begin
          cnt <= cnt + 1'b1;
        end
        OP_PUBLISH: begin
          out_start       <= res_seg.start;
          out_end         <= res_seg.stop;
          out_size        <= res_seg.size;
          out_owner       <= res_seg.owner;
          status          <= res_st;
          entry_count_out <= cnt;
        end
        default: begin
          rv <= rv;
        end
      endcase
    end
  end
endmodule

FILE: design/variable_partition_allocator.sv
// Variable partition allocator: first/best/worst/next fit over a segment map.
// Per command, with N entries scanned and M shifted: init and the unused code
// skip the scan; no fit, exact fit, map full and release miss scan N entries;
// split and merge scan N entries, then shift M and write the result segments.
// One command in flight. Sync active-high reset empties the map, sets first
// fit and mem_size 2^16. Uses vpa_pkg, vpa_ctrl, vpa_dp, vpa_ram.
`timescale 1ns / 1ps
module variable_partition_allocator #(
  parameter int MAP_ENTRIES = vpa_pkg::MAP_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [vpa_pkg::SIZE_BITS-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [vpa_pkg::SIZE_BITS-1:0]      req_size,
  input  logic [vpa_pkg::OWNER_BITS-1:0]     owner_id,
  input  logic [vpa_pkg::ADDR_BITS-1:0]      scan_from,
  input  logic [vpa_pkg::ADDR_BITS-1:0]      block_start,
  input  logic [vpa_pkg::ADDR_BITS-1:0]      block_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vpa_pkg::ADDR_BITS-1:0]      out_start,
  output logic [vpa_pkg::ADDR_BITS-1:0]      out_end,
  output logic [vpa_pkg::SIZE_BITS-1:0]      out_size,
  output logic [vpa_pkg::OWNER_BITS-1:0]     out_owner,
  output logic [1:0]                         status,
  output logic [$clog2(MAP_ENTRIES+1)-1:0]   entry_count_out
);
  import vpa_pkg::*;

  localparam int CW = $clog2(MAP_ENTRIES + 1);

  logic [1:0]           fit_policy;
  logic [SIZE_BITS-1:0] mem_size;
  dp_op_t               op;
  dp_stat_t             stat;

  // Configuration registers: user must keep them written only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
      mem_size   <= SIZE_BITS'(1) << ADDR_BITS;
    end else if (cfg_write) begin
      if (cfg_index == CFG_FIT_POLICY) begin
        fit_policy <= cfg_data[1:0];
      end else begin
        mem_size <= cfg_data;
      end
    end
  end

  // Sequencer: accepts one input beat, steps the datapath, publishes result.
  vpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // Datapath: map RAM, fit trackers, merge/split moves and the output beat
  // register, which holds a finished result while the next command runs.
  vpa_dp #(.MAP_ENTRIES(MAP_ENTRIES)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .stat            (stat),
    .fit_policy      (fit_policy),
    .mem_size        (mem_size),
    .command         (command),
    .req_size        (req_size),
    .owner_id        (owner_id),
    .scan_from       (scan_from),
    .block_start     (block_start),
    .block_end       (block_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start       (out_start),
    .out_end         (out_end),
    .out_size        (out_size),
    .out_owner       (out_owner),
    .status          (status),
    .entry_count_out (entry_count_out)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count_out <= CW'(MAP_ENTRIES)))
    else $error("entry count beyond map depth");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |->
      (entry_count_out == CW'(MAP_ENTRIES) && out_size == '0))
    else $error("map full reported with room left or segment data");

  a_seg_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK && out_size != '0) |->
      (out_end == ADDR_BITS'(out_start + out_size - 1'b1)))
    else $error("allocated segment end does not match start and size");
endmodule
